// ===== src/gfpe_pkg.sv =====
// ----------------------------------------------------------------------------
// GF(2^8) polynomial evaluator package
// Shared constants, register codes and the field multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package gfpe_pkg;

   localparam int COEFF_COUNT_MAX = 14;
   localparam int INV_STAGES = 8;

   localparam logic [7:0] FIELD_POLY_RESET = 8'h2B;
   localparam logic [3:0] POLY_DEGREE_RESET = 4'd13;

   // The inverse is value^254; each inverse cell handles one exponent bit.
   localparam logic [7:0] INV_EXPONENT = 8'd254;

   typedef enum logic [1:0] {
      REG_FIELD_POLY  = 2'd0,
      REG_COEFF_LOW   = 2'd1,
      REG_COEFF_HIGH  = 2'd2,
      REG_POLY_DEGREE = 2'd3
   } reg_index_type;

   // Product of a and b modulo x^8 + poly.
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] poly);
      logic [7:0] acc;
      logic [7:0] x;
      logic       carry;
      acc = 8'd0;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x;
         end
         carry = x[7];
         x = {x[6:0], 1'b0};
         if (carry) begin
            x = x ^ poly;
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// ===== src/gfpe_horner_cell.sv =====
// ----------------------------------------------------------------------------
// Horner cell
// One step of Horner evaluation: acc times point, plus one coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module gfpe_horner_cell
   import gfpe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] field_poly,
   input  wire logic [7:0] coeff,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] in_point,
   input  wire logic [7:0] in_acc,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [7:0]      out_point,
   output logic [7:0]      out_acc
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] point_ff;
   logic [7:0] acc_ff;
   logic [7:0] acc_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign acc_in = gf_mul(in_acc, in_point, field_poly) ^ coeff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         point_ff <= in_point;
         acc_ff <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_point = point_ff;
   assign out_acc = acc_ff;

endmodule

`default_nettype wire

// ===== src/gfpe_inverse_cell.sv =====
// ----------------------------------------------------------------------------
// Inverse cell
// One square-and-multiply step of the power chain that forms value^254.
// ----------------------------------------------------------------------------
`default_nettype none

module gfpe_inverse_cell
   import gfpe_pkg::*;
#(
   parameter bit MUL_EN = 1'b1
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] field_poly,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] in_value,
   input  wire logic [7:0] in_base,
   input  wire logic [7:0] in_result,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [7:0]      out_value,
   output logic [7:0]      out_base,
   output logic [7:0]      out_result
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] value_ff;
   logic [7:0] base_ff;
   logic [7:0] base_in;
   logic [7:0] result_ff;
   logic [7:0] result_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign base_in = gf_mul(in_base, in_base, field_poly);
   assign result_in = MUL_EN ? gf_mul(in_result, in_base, field_poly) : in_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         value_ff <= in_value;
         base_ff <= base_in;
         result_ff <= result_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_base = base_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

// ===== src/gf256_polynomial_evaluator.sv =====
// ----------------------------------------------------------------------------
// GF(2^8) polynomial evaluator
// Evaluates the configured polynomial at each requested point and returns the
// value, its inverse and a root flag.
// ----------------------------------------------------------------------------
// Pipeline: the Horner cells feed the inverse cells; every cell is one register stage.
// Throughput: one request per cycle while rsp_tready is high; each Horner cell and
// each inverse cell holds one request, and stalls only when it is full and its successor cannot accept.
// Reset: synchronous; clears all cell valid bits and loads the register
// defaults (field polynomial 0x2B, coefficients 0, degree 13).
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_polynomial_evaluator
   import gfpe_pkg::*;
#(
   parameter int MAX_COEFFS = COEFF_COUNT_MAX
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: point[7:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // rsp_tdata: value[7:0], value_inverse[15:8], is_root[16], zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [3:0] TOP_MAX = 4'(MAX_COEFFS - 1);

   logic [7:0]    field_poly_ff;
   logic [63:0]   coeff_low_ff;
   logic [47:0]   coeff_high_ff;
   logic [3:0]    poly_degree_ff;
   logic          csr_write;
   reg_index_type csr_index;
   logic [3:0]    top_index;
   logic [111:0]  coeff_all;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = reg_index_type'(csr_paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         field_poly_ff <= FIELD_POLY_RESET;
         coeff_low_ff <= 64'd0;
         coeff_high_ff <= 48'd0;
         poly_degree_ff <= POLY_DEGREE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_FIELD_POLY: begin
               field_poly_ff <= csr_pwdata[7:0];
            end
            REG_COEFF_LOW: begin
               coeff_low_ff <= csr_pwdata;
            end
            REG_COEFF_HIGH: begin
               coeff_high_ff <= csr_pwdata[47:0];
            end
            REG_POLY_DEGREE: begin
               poly_degree_ff <= csr_pwdata[3:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FIELD_POLY:  csr_prdata = {56'd0, field_poly_ff};
         REG_COEFF_LOW:   csr_prdata = coeff_low_ff;
         REG_COEFF_HIGH:  csr_prdata = {16'd0, coeff_high_ff};
         REG_POLY_DEGREE: csr_prdata = {60'd0, poly_degree_ff};
         default:         csr_prdata = 64'd0;
      endcase
   end

   // A degree beyond the last cell saturates; coefficients above it are masked.
   assign top_index = (poly_degree_ff > TOP_MAX) ? TOP_MAX : poly_degree_ff;
   assign coeff_all = {coeff_high_ff, coeff_low_ff};

   logic       h_valid [0:MAX_COEFFS];
   logic       h_ready [0:MAX_COEFFS];
   logic [7:0] h_point [0:MAX_COEFFS];
   logic [7:0] h_acc   [0:MAX_COEFFS];

   assign h_valid[0] = req_tvalid;
   assign req_tready = h_ready[0];
   assign h_point[0] = req_tdata;
   assign h_acc[0] = 8'd0;

   // Cell k adds the coefficient of index MAX_COEFFS-1-k, highest first.
   for (genvar k = 0; k < MAX_COEFFS; k++) begin : g_horner
      localparam int IDX = MAX_COEFFS - 1 - k;
      logic [7:0] coeff;
      assign coeff = (4'(IDX) <= top_index) ? coeff_all[8*IDX +: 8] : 8'd0;

      gfpe_horner_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .field_poly (field_poly_ff),
         .coeff      (coeff),
         .in_valid   (h_valid[k]),
         .in_ready   (h_ready[k]),
         .in_point   (h_point[k]),
         .in_acc     (h_acc[k]),
         .out_valid  (h_valid[k+1]),
         .out_ready  (h_ready[k+1]),
         .out_point  (h_point[k+1]),
         .out_acc    (h_acc[k+1])
      );
   end

   logic       i_valid  [0:INV_STAGES];
   logic       i_ready  [0:INV_STAGES];
   logic [7:0] i_value  [0:INV_STAGES];
   logic [7:0] i_base   [0:INV_STAGES];
   logic [7:0] i_result [0:INV_STAGES];

   assign i_valid[0] = h_valid[MAX_COEFFS];
   assign h_ready[MAX_COEFFS] = i_ready[0];
   assign i_value[0] = h_acc[MAX_COEFFS];
   assign i_base[0] = h_acc[MAX_COEFFS];
   assign i_result[0] = 8'd1;

   // A zero value gives a zero power, so the inverse reads 0 on its own.
   for (genvar s = 0; s < INV_STAGES; s++) begin : g_inverse
      gfpe_inverse_cell #(
         .MUL_EN (INV_EXPONENT[s])
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .field_poly (field_poly_ff),
         .in_valid   (i_valid[s]),
         .in_ready   (i_ready[s]),
         .in_value   (i_value[s]),
         .in_base    (i_base[s]),
         .in_result  (i_result[s]),
         .out_valid  (i_valid[s+1]),
         .out_ready  (i_ready[s+1]),
         .out_value  (i_value[s+1]),
         .out_base   (i_base[s+1]),
         .out_result (i_result[s+1])
      );
   end

   assign rsp_tvalid = i_valid[INV_STAGES];
   assign i_ready[INV_STAGES] = rsp_tready;
   assign rsp_tdata = {7'd0, (i_value[INV_STAGES] == 8'd0), i_result[INV_STAGES],
                       i_value[INV_STAGES]};

   // The last square is not needed by the result.
   logic unused_base;
   assign unused_base = ^i_base[INV_STAGES] ^ ^h_point[MAX_COEFFS];

endmodule

`default_nettype wire
